// ----- hw/rtl/nrb_pkg.sv -----
`default_nettype none
package nrb_pkg;

   localparam int VALUE_WIDTH   = 32;
   localparam int FRACTION_BITS = 16;
   localparam int MAX_DEGREE    = 16;
   localparam int DEGREE_WIDTH  = 5;
   localparam int PROD_WIDTH    = 2 * VALUE_WIDTH;
   localparam int PC_WIDTH      = 3;

   localparam logic [VALUE_WIDTH-1:0] FIX_ONE =
      VALUE_WIDTH'(64'd1 << FRACTION_BITS);
   localparam logic [DEGREE_WIDTH-1:0] DEGREE_LIMIT = DEGREE_WIDTH'(MAX_DEGREE);

   localparam logic [PC_WIDTH-1:0] STEP_WAIT   = 3'd0;
   localparam logic [PC_WIDTH-1:0] STEP_CHECK  = 3'd1;
   localparam logic [PC_WIDTH-1:0] STEP_TEST   = 3'd2;
   localparam logic [PC_WIDTH-1:0] STEP_MUL    = 3'd3;
   localparam logic [PC_WIDTH-1:0] STEP_UPDATE = 3'd4;
   localparam logic [PC_WIDTH-1:0] STEP_FINISH = 3'd5;
   localparam logic [PC_WIDTH-1:0] STEP_ERROR  = 3'd6;

   typedef enum logic [2:0] {
      OP_NOP    = 3'd0,
      OP_LOAD   = 3'd1,
      OP_MID    = 3'd2,
      OP_MUL    = 3'd3,
      OP_UPDATE = 3'd4,
      OP_RESULT = 3'd5,
      OP_ERROR  = 3'd6
   } op_type;

   typedef enum logic [2:0] {
      COND_NEXT     = 3'd0,
      COND_GOTO     = 3'd1,
      COND_NO_START = 3'd2,
      COND_SPECIAL  = 3'd3,
      COND_DONE     = 3'd4,
      COND_MORE     = 3'd5
   } cond_type;

   typedef struct packed {
      op_type              op;
      cond_type            cond;
      logic [PC_WIDTH-1:0] target;
   } uword_type;

   function automatic uword_type micro_rom(input logic [PC_WIDTH-1:0] pc);
      uword_type w;
      begin
         case (pc)
            STEP_WAIT:   w = '{OP_LOAD,   COND_NO_START, STEP_WAIT};
            STEP_CHECK:  w = '{OP_NOP,    COND_SPECIAL,  STEP_ERROR};
            STEP_TEST:   w = '{OP_MID,    COND_DONE,     STEP_FINISH};
            STEP_MUL:    w = '{OP_MUL,    COND_MORE,     STEP_MUL};
            STEP_UPDATE: w = '{OP_UPDATE, COND_GOTO,     STEP_TEST};
            STEP_FINISH: w = '{OP_RESULT, COND_GOTO,     STEP_WAIT};
            STEP_ERROR:  w = '{OP_ERROR,  COND_GOTO,     STEP_WAIT};
            default:     w = '{OP_NOP,    COND_GOTO,     STEP_WAIT};
         endcase
         return w;
      end
   endfunction

   function automatic logic [VALUE_WIDTH-1:0] fix_mul_sat(
      input logic [PROD_WIDTH-1:0] prod
   );
      begin
         if (prod[PROD_WIDTH-1 -: FRACTION_BITS] != '0) begin
            return '1;
         end
         return prod[FRACTION_BITS +: VALUE_WIDTH];
      end
   endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/nth_root_bisection_top.sv -----
`default_nettype none
// Each bisection step takes the midpoint, raises it to the root degree D (capped at 16) by
// repeated multiplies, then narrows the interval; up to 16 steps for a radicand below one, 32 otherwise.
// Zero radicand or zero degree skips the bisection and returns zero. One item at a time.
// Each multiply step uses the one multiplier.
// Synchronous active-high reset returns the sequencer to its wait step, no result pending.
// The result is a one-cycle strobe; the receiver cannot stall it.
module nth_root_bisection_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [nrb_pkg::VALUE_WIDTH-1:0]   req_radicand,
   input  wire logic [nrb_pkg::DEGREE_WIDTH-1:0]  req_root_degree,
   output logic                                   rsp_valid,
   output logic [nrb_pkg::VALUE_WIDTH-1:0]        rsp_root_value,
   output logic                                   rsp_degree_error
);
   import nrb_pkg::*;

   logic [PC_WIDTH-1:0]     pc_ff, pc_in;
   logic [VALUE_WIDTH-1:0]  x_ff, x_in;
   logic [DEGREE_WIDTH-1:0] deg_ff, deg_in;
   logic [VALUE_WIDTH-1:0]  lo_ff, lo_in;
   logic [VALUE_WIDTH-1:0]  hi_ff, hi_in;
   logic [VALUE_WIDTH-1:0]  mid_ff, mid_in;
   logic [VALUE_WIDTH-1:0]  pw_ff, pw_in;
   logic [DEGREE_WIDTH-1:0] cnt_ff, cnt_in;
   logic                    valid_ff, valid_in;
   logic [VALUE_WIDTH-1:0]  root_ff, root_in;
   logic                    err_ff, err_in;

   uword_type               uw;
   logic [VALUE_WIDTH-1:0]  diff;
   logic [VALUE_WIDTH-1:0]  mid;
   logic [PROD_WIDTH-1:0]   prod;
   logic [DEGREE_WIDTH-1:0] cnt_next;
   logic                    special;
   logic                    converged;
   logic                    more;
   logic                    take;

   assign uw        = micro_rom(pc_ff);
   assign diff      = hi_ff - lo_ff;
   assign mid       = lo_ff + (diff >> 1);
   assign prod      = PROD_WIDTH'(pw_ff) * PROD_WIDTH'(mid_ff);
   assign cnt_next  = cnt_ff + DEGREE_WIDTH'(1);
   assign special   = (x_ff == '0) || (deg_ff == '0);
   assign converged = (diff[VALUE_WIDTH-1:1] == '0);
   assign more      = (cnt_next != deg_ff);

   always_comb begin
      unique case (uw.cond)
         COND_NEXT:     take = 1'b0;
         COND_GOTO:     take = 1'b1;
         COND_NO_START: take = !start;
         COND_SPECIAL:  take = special;
         COND_DONE:     take = converged;
         COND_MORE:     take = more;
         default:       take = 1'b1;
      endcase
      pc_in = take ? uw.target : pc_ff + PC_WIDTH'(1);
   end

   always_comb begin
      x_in     = x_ff;
      deg_in   = deg_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      mid_in   = mid_ff;
      pw_in    = pw_ff;
      cnt_in   = cnt_ff;
      valid_in = 1'b0;
      root_in  = root_ff;
      err_in   = err_ff;
      unique case (uw.op)
         OP_NOP: begin
         end
         OP_LOAD: begin
            if (start) begin
               x_in   = req_radicand;
               deg_in = (req_root_degree > DEGREE_LIMIT) ? DEGREE_LIMIT : req_root_degree;
               if (req_radicand < FIX_ONE) begin
                  lo_in = '0;
                  hi_in = FIX_ONE;
               end else begin
                  lo_in = FIX_ONE;
                  hi_in = req_radicand;
               end
            end
         end
         OP_MID: begin
            mid_in = mid;
            pw_in  = FIX_ONE;
            cnt_in = '0;
         end
         OP_MUL: begin
            pw_in  = fix_mul_sat(prod);
            cnt_in = cnt_next;
         end
         OP_UPDATE: begin
            if (pw_ff < x_ff) begin
               lo_in = mid_ff;
            end else begin
               hi_in = mid_ff;
            end
         end
         OP_RESULT: begin
            valid_in = 1'b1;
            root_in  = mid;
            err_in   = 1'b0;
         end
         OP_ERROR: begin
            valid_in = 1'b1;
            root_in  = '0;
            err_in   = (x_ff != '0);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff    <= STEP_WAIT;
         valid_ff <= 1'b0;
      end else begin
         pc_ff    <= pc_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      deg_ff  <= deg_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      mid_ff  <= mid_in;
      pw_ff   <= pw_in;
      cnt_ff  <= cnt_in;
      root_ff <= root_in;
      err_ff  <= err_in;
   end

   assign busy             = (pc_ff != STEP_WAIT);
   assign rsp_valid        = valid_ff;
   assign rsp_root_value   = root_ff;
   assign rsp_degree_error = err_ff;

endmodule
`default_nettype wire
